@@ design/udm_pkg.sv @@
// ----------------------------------------------------------------------------
// udm_pkg
// plan kind codes and sequencer state type for the unsigned division planner
// ----------------------------------------------------------------------------
package udm_pkg;

   // plan kinds on rsp_plan_kind
   localparam logic [2:0] KIND_ZERO     = 3'd0;
   localparam logic [2:0] KIND_COMPARE  = 3'd1;
   localparam logic [2:0] KIND_SHIFT    = 3'd2;
   localparam logic [2:0] KIND_MULHI    = 3'd3;
   localparam logic [2:0] KIND_ADDFIX   = 3'd4;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_TZ     = 7'b0000010,
      ST_LEN    = 7'b0000100,
      ST_DIV_LO = 7'b0001000,
      ST_DIV_HI = 7'b0010000,
      ST_HALVE  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } udm_state_type;

endpackage

@@ design/udiv_magic_multiplier.sv @@
// ----------------------------------------------------------------------------
// udiv_magic_multiplier
// plans division of an unsigned word by a constant divisor without a divider
// ----------------------------------------------------------------------------
// steps: zero and compare plans go straight to the result; shift plans strip
//   trailing zeros first; multiply plans also scan the length, divide for the low
//   and high bounds and halve them, and a retry on the odd part repeats the length
//   scan, both divisions and the halving
// throughput: one beat at a time, req_stall is high until the sequencer is idle
// reset: synchronous, clears the sequencer and rsp_valid; no clearing pass
// ----------------------------------------------------------------------------
module udiv_magic_multiplier #(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_plan_kind,
   output logic [31:0] rsp_magic_multiplier,
   output logic [4:0]  rsp_pre_shift,
   output logic [4:0]  rsp_post_shift
);
   import udm_pkg::*;

   // quotient width: the round-up bounds stay below 2^(WORD_BITS+2)
   localparam int QW = WORD_BITS + 2;
   // width of shift counts and bit positions (up to 2*WORD_BITS-1)
   localparam int SW = $clog2(2 * WORD_BITS);
   // width for the magic result before it is cut to 32 bits
   localparam int XW = (QW > 32) ? QW : 32;
   localparam logic [31:0] HALF = 32'(64'(1) << (WORD_BITS - 1));

   udm_state_type         state_ff, state_in;
   logic [WORD_BITS-1:0]  work_ff, work_in;    // shift register for tz and length scans
   logic [WORD_BITS-1:0]  dv_ff, dv_in;        // divisor of the current pass
   logic [WORD_BITS-1:0]  odd_ff, odd_in;      // odd part of the divisor
   logic [SW-1:0]         s_ff, s_in;          // trailing zeros
   logic [SW-1:0]         l_ff, l_in;          // log2 ceiling, then counted down
   logic [SW-1:0]         top_ff, top_in;      // exponent of the dividend
   logic [SW-1:0]         lowsh_ff, lowsh_in;  // exponent of the round-up term
   logic [SW-1:0]         cnt_ff, cnt_in;      // dividend bit position
   logic [WORD_BITS-1:0]  rem_ff, rem_in;      // partial remainder
   logic [QW-1:0]         q_ff, q_in;          // quotient being built
   logic [QW-1:0]         lo_ff, lo_in;
   logic [QW-1:0]         hi_ff, hi_in;
   logic                  retry_ff, retry_in;
   logic [2:0]            kind_ff, kind_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_kind_ff, rsp_kind_in;
   logic [31:0]           rsp_magic_ff, rsp_magic_in;
   logic [4:0]            rsp_pre_ff, rsp_pre_in;
   logic [4:0]            rsp_post_ff, rsp_post_in;

   logic                  req_take;
   logic                  rsp_free;
   logic                  div_bit;
   logic [WORD_BITS-1:0]  rem_sh;
   logic                  rem_ge;
   logic [WORD_BITS-1:0]  rem_nx;
   logic [QW-1:0]         q_nx;
   logic [SW-1:0]         top_calc;
   logic [SW-1:0]         lowsh_calc;
   logic [XW-1:0]         magic_full;

   // partial remainder seed: dividend bits that sit above the quotient window
   function automatic logic [WORD_BITS-1:0] seed_rem(input logic [SW-1:0] top,
                                                     input logic [SW-1:0] lowsh,
                                                     input logic use_low);
      logic [WORD_BITS-1:0] r;
      r = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         r[j] = (int'(top) == QW + j) || (use_low && (int'(lowsh) == QW + j));
      end
      return r;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // shared restoring divider step: one quotient bit per cycle
   assign div_bit = (cnt_ff == top_ff) || ((state_ff == ST_DIV_HI) && (cnt_ff == lowsh_ff));
   assign rem_sh  = {rem_ff[WORD_BITS-2:0], div_bit};
   assign rem_ge  = (rem_sh >= dv_ff);
   assign rem_nx  = rem_ge ? (rem_sh - dv_ff) : rem_sh;
   assign q_nx    = {q_ff[QW-2:0], rem_ge};

   // exponents once the length scan ends; the retry pass uses precision WORD_BITS-s
   assign top_calc   = SW'(WORD_BITS) + l_ff;
   assign lowsh_calc = retry_ff ? (l_ff + s_ff) : l_ff;

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      dv_in    = dv_ff;
      odd_in   = odd_ff;
      s_in     = s_ff;
      l_in     = l_ff;
      top_in   = top_ff;
      lowsh_in = lowsh_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      retry_in = retry_ff;
      kind_in  = kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               work_in  = req_divisor[WORD_BITS-1:0];
               dv_in    = req_divisor[WORD_BITS-1:0];
               s_in     = '0;
               retry_in = 1'b0;
               priority if (req_divisor == 32'd0) begin
                  kind_in  = KIND_ZERO;
                  state_in = ST_FINISH;
               end else if (req_divisor >= HALF) begin
                  kind_in  = KIND_COMPARE;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_TZ;
               end
            end
         end

         // strip trailing zeros one bit a cycle
         ST_TZ: begin
            if (!work_ff[0]) begin
               work_in = work_ff >> 1;
               s_in    = s_ff + SW'(1);
            end else if (work_ff == WORD_BITS'(1)) begin
               kind_in  = KIND_SHIFT;
               state_in = ST_FINISH;
            end else begin
               odd_in   = work_ff;
               work_in  = dv_ff - WORD_BITS'(1);
               l_in     = '0;
               state_in = ST_LEN;
            end
         end

         // l = bit length of (divisor - 1)
         ST_LEN: begin
            if (work_ff != '0) begin
               work_in = work_ff >> 1;
               l_in    = l_ff + SW'(1);
            end else begin
               top_in   = top_calc;
               lowsh_in = lowsh_calc;
               rem_in   = seed_rem(top_calc, lowsh_calc, 1'b0);
               cnt_in   = SW'(QW - 1);
               q_in     = '0;
               state_in = ST_DIV_LO;
            end
         end

         // low bound: 2^top / d
         ST_DIV_LO: begin
            rem_in = rem_nx;
            q_in   = q_nx;
            if (cnt_ff == '0) begin
               lo_in    = q_nx;
               rem_in   = seed_rem(top_ff, lowsh_ff, 1'b1);
               cnt_in   = SW'(QW - 1);
               q_in     = '0;
               state_in = ST_DIV_HI;
            end else begin
               cnt_in = cnt_ff - SW'(1);
            end
         end

         // high bound: (2^top + 2^lowsh) / d
         ST_DIV_HI: begin
            rem_in = rem_nx;
            q_in   = q_nx;
            if (cnt_ff == '0) begin
               hi_in    = q_nx;
               state_in = ST_HALVE;
            end else begin
               cnt_in = cnt_ff - SW'(1);
            end
         end

         // halve both bounds while their halves still differ and l is nonzero, then pick the plan
         ST_HALVE: begin
            if (((lo_ff >> 1) < (hi_ff >> 1)) && (l_ff != '0)) begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
               l_in  = l_ff - SW'(1);
            end else if (hi_ff[QW-1:WORD_BITS] == '0) begin
               kind_in  = KIND_MULHI;
               if (!retry_ff) begin
                  s_in = '0;
               end
               state_in = ST_FINISH;
            end else if (!retry_ff && (s_ff != '0)) begin
               // multiplier overflowed the word: retry on the odd part
               retry_in = 1'b1;
               dv_in    = odd_ff;
               work_in  = odd_ff - WORD_BITS'(1);
               l_in     = '0;
               state_in = ST_LEN;
            end else begin
               kind_in  = KIND_ADDFIX;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat from the plan registers
   assign magic_full = XW'(hi_ff);

   always_comb begin
      rsp_kind_in  = rsp_kind_ff;
      rsp_magic_in = rsp_magic_ff;
      rsp_pre_in   = rsp_pre_ff;
      rsp_post_in  = rsp_post_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_magic_in = '0;
         rsp_pre_in   = '0;
         rsp_post_in  = '0;
         unique case (kind_ff)
            KIND_SHIFT: begin
               rsp_pre_in = 5'(s_ff);
            end
            KIND_MULHI: begin
               rsp_magic_in = magic_full[31:0];
               rsp_pre_in   = 5'(s_ff);
               rsp_post_in  = 5'(l_ff);
            end
            KIND_ADDFIX: begin
               // m minus 2^WORD_BITS, post shift l - 1
               rsp_magic_in = 32'(magic_full - (XW'(1) << WORD_BITS));
               rsp_post_in  = (l_ff != '0) ? 5'(l_ff - SW'(1)) : 5'd0;
            end
            default: begin
               rsp_magic_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      dv_ff        <= dv_in;
      odd_ff       <= odd_in;
      s_ff         <= s_in;
      l_ff         <= l_in;
      top_ff       <= top_in;
      lowsh_ff     <= lowsh_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      retry_ff     <= retry_in;
      kind_ff      <= kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_magic_ff <= rsp_magic_in;
      rsp_pre_ff   <= rsp_pre_in;
      rsp_post_ff  <= rsp_post_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_plan_kind        = rsp_kind_ff;
   assign rsp_magic_multiplier = rsp_magic_ff;
   assign rsp_pre_shift        = rsp_pre_ff;
   assign rsp_post_shift       = rsp_post_ff;

endmodule

@@ design/udm_checker.sv @@
// ----------------------------------------------------------------------------
// udm_checker
// port-level checks for the unsigned division planner
// ----------------------------------------------------------------------------
module udm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_plan_kind,
   input logic [31:0] rsp_magic_multiplier,
   input logic [4:0]  rsp_pre_shift,
   input logic [4:0]  rsp_post_shift
);
   import udm_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plan_kind)
         && $stable(rsp_magic_multiplier) && $stable(rsp_pre_shift)
         && $stable(rsp_post_shift))
      else $error("result beat changed while stalled");

   // one divisor at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a plan is in progress");

   // zero and compare plans carry no multiplier and no shifts
   a_trivial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_plan_kind == KIND_ZERO || rsp_plan_kind == KIND_COMPARE)
      |-> rsp_magic_multiplier == 32'd0 && rsp_pre_shift == 5'd0
         && rsp_post_shift == 5'd0)
      else $error("zero or compare plan with nonzero fields");

   // shift plans carry no multiplier and no post shift
   a_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plan_kind == KIND_SHIFT
      |-> rsp_magic_multiplier == 32'd0 && rsp_post_shift == 5'd0)
      else $error("shift plan with multiplier or post shift");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind udiv_magic_multiplier udm_checker u_udm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_plan_kind        (rsp_plan_kind),
   .rsp_magic_multiplier (rsp_magic_multiplier),
   .rsp_pre_shift        (rsp_pre_shift),
   .rsp_post_shift       (rsp_post_shift)
);

@@ bench/udm_plan_checker.sv @@
// ----------------------------------------------------------------------------
// udm_plan_checker
// watches both channels of the division planner, predicts each plan from the
// accepted divisor and compares the returned plan field by field
// ----------------------------------------------------------------------------
module udm_plan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_divisor,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_plan_kind,
   input  logic [31:0] rsp_magic_multiplier,
   input  logic [4:0]  rsp_pre_shift,
   input  logic [4:0]  rsp_post_shift,
   output int          fail_count,
   output int          plans_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import udm_pkg::*;

   localparam int unsigned WORD_BITS = 32;

   typedef struct packed {
      logic [31:0] divisor;
      logic [2:0]  kind;
      logic [31:0] magic;
      logic [4:0]  pre;
      logic [4:0]  post;
   } division_plan_type;

   division_plan_type expected_plans [$];

   initial begin
      fail_count    = 0;
      plans_pending = 0;
   end

   function automatic int unsigned width_of(input logic [63:0] x);
      for (int i = 63; i >= 0; i--) begin
         if (x[i]) return i + 1;
      end
      return 0;
   endfunction

   // round-up multiplier at precision prec; shift count comes back in shift_out
   function automatic logic [63:0] round_up_multiplier(input logic [63:0] d,
                                                       input int unsigned prec,
                                                       output int unsigned shift_out);
      int unsigned l, top, lowsh;
      logic [63:0] lo, hi;
      l     = width_of(d - 64'd1);
      top   = WORD_BITS + l;
      lowsh = top - prec;
      if (top > 63) top = 63;
      if (lowsh > top) lowsh = 0;
      lo = (64'd1 << top) / d;
      hi = ((64'd1 << top) + (64'd1 << lowsh)) / d;
      while ((lo >> 1) < (hi >> 1) && l > 0) begin
         lo = lo >> 1;
         hi = hi >> 1;
         l--;
      end
      shift_out = l;
      return hi;
   endfunction

   function automatic division_plan_type plan_for_divisor(input logic [31:0] divisor);
      division_plan_type plan;
      logic [63:0] d, m;
      int unsigned tz, l;
      plan         = '0;
      plan.divisor = divisor;
      d            = {32'd0, divisor};
      if (d == 64'd0) begin
         plan.kind = KIND_ZERO;
      end else if (d >= (64'd1 << (WORD_BITS - 1))) begin
         plan.kind = KIND_COMPARE;
      end else begin
         tz = 0;
         while (!d[tz]) tz++;
         if (d == (64'd1 << tz)) begin
            plan.kind = KIND_SHIFT;
            plan.pre  = tz[4:0];
         end else begin
            m = round_up_multiplier(d, WORD_BITS, l);
            // multiplier too wide: retry on the odd part with reduced precision
            if (m < (64'd1 << WORD_BITS)) tz = 0;
            else if (tz > 0) m = round_up_multiplier(d >> tz, WORD_BITS - tz, l);
            if (m < (64'd1 << WORD_BITS)) begin
               plan.kind  = KIND_MULHI;
               plan.magic = m[31:0];
               plan.pre   = tz[4:0];
               plan.post  = l[4:0];
            end else begin
               plan.kind  = KIND_ADDFIX;
               plan.magic = m[31:0];
               plan.post  = (l > 0) ? 5'(l - 1) : 5'd0;
            end
         end
      end
      return plan;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] divisor,
                                input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: divisor 0x%08h %s expected 0x%0h actual 0x%0h",
                  $time, divisor, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      division_plan_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_plans.size() == 0) begin
               $display("%0t: plan beat with none expected, expected nothing actual kind %0d",
                        $time, rsp_plan_kind);
               fail_count++;
            end else begin
               want = expected_plans.pop_front();
               compare_field("plan_kind", want.divisor, want.kind, rsp_plan_kind);
               compare_field("magic_multiplier", want.divisor, want.magic,
                             rsp_magic_multiplier);
               compare_field("pre_shift", want.divisor, want.pre, rsp_pre_shift);
               compare_field("post_shift", want.divisor, want.post, rsp_post_shift);
            end
         end
         if (req_valid && !req_stall) expected_plans.push_back(plan_for_divisor(req_divisor));
      end
      plans_pending <= expected_plans.size();
   end

endmodule

@@ bench/udiv_magic_multiplier_tb.sv @@
// ----------------------------------------------------------------------------
// udiv_magic_multiplier_tb
// drives divisors into the division planner, directed corners first and then
// a weighted random mix, with random idle bursts on both channels; the plan
// checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module udiv_magic_multiplier_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import udm_pkg::*;

   localparam int RANDOM_DIVISORS = 1200;
   localparam int QUIET_TAIL      = 200;      // last divisors sent with no idling
   localparam int DRAIN_CYCLES    = 300;      // settling wait after the last plan
   localparam int CYCLE_LIMIT     = 1500000;  // several times the slowest run

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [31:0] req_divisor = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [2:0]  rsp_plan_kind;
   logic [31:0] rsp_magic_multiplier;
   logic [4:0]  rsp_pre_shift;
   logic [4:0]  rsp_post_shift;
   int          fail_count;
   int          plans_pending;
   int unsigned cycle_count = 0;
   bit          idle_on     = 1'b1;

   // corners: zero, one, every plan kind, add-fixup, odd-part retry, the
   // compare boundary and the largest word
   logic [31:0] corner_divisors [22] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10, 32'd12, 32'd14,
      32'd641, 32'd1000000007, 32'h4000_0000, 32'h6000_0000, 32'h5555_5555,
      32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
      32'hFFFF_FFFF, 32'h0000_FFFF
   };

   udiv_magic_multiplier dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_divisor          (req_divisor),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_plan_kind        (rsp_plan_kind),
      .rsp_magic_multiplier (rsp_magic_multiplier),
      .rsp_pre_shift        (rsp_pre_shift),
      .rsp_post_shift       (rsp_post_shift)
   );

   udm_plan_checker u_plan_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_divisor          (req_divisor),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_plan_kind        (rsp_plan_kind),
      .rsp_magic_multiplier (rsp_magic_multiplier),
      .rsp_pre_shift        (rsp_pre_shift),
      .rsp_post_shift       (rsp_post_shift),
      .fail_count           (fail_count),
      .plans_pending        (plans_pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("udiv_magic_multiplier_tb NOT OK");
         $finish;
      end
   end

   // result side backpressure in random bursts
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // weighted mix so every plan kind and the retry path come up often
   function automatic logic [31:0] random_divisor();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return $urandom;
      // random bit length, mostly multiply plans
      if (pick < 40) return $urandom >> $urandom_range(0, 31);
      if (pick < 58) return $urandom_range(1, 400);
      // even divisors with an odd part, drives the retry
      if (pick < 74) return ((($urandom >> $urandom_range(1, 31)) | 32'd1)
                             << $urandom_range(1, 30));
      if (pick < 81) return 32'd1 << $urandom_range(0, 31);
      if (pick < 84) return 32'd0;
      // around the compare boundary
      if (pick < 92) return 32'h8000_0000 + $urandom_range(0, 16) - 32'd8;
      return (32'd1 << $urandom_range(2, 31)) + $urandom_range(0, 6) - 32'd3;
   endfunction

   // one divisor beat, with an optional idle burst ahead of it
   task automatic send_divisor(input logic [31:0] divisor);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_divisor <= divisor;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_divisors[i]) send_divisor(corner_divisors[i]);

      // idle stretches alternate with quiet ones, tail runs flat out
      for (int i = 0; i < RANDOM_DIVISORS; i++) begin
         idle_on = (i < RANDOM_DIVISORS - QUIET_TAIL) && ((i / 150) % 3 != 2);
         send_divisor(random_divisor());
      end
      idle_on = 1'b0;
      req_valid <= 1'b0;

      do @(posedge clock); while (plans_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("udiv_magic_multiplier_tb OK");
      end else begin
         $display("udiv_magic_multiplier_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/udm_pkg.sv
design/udiv_magic_multiplier.sv
design/udm_checker.sv
bench/udm_plan_checker.sv
bench/udiv_magic_multiplier_tb.sv
